// File: hdl/knn_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// knn_pkg
// Shared types and constants of the two-class nearest-neighbor classifier.
// ============================================================================
package knn_pkg;

    localparam int CFG_W       = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int SLOT_W      = 4;
    localparam int FIELD_W     = 16;
    localparam int VOTE_W      = 5;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_POINTS_IN_USE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_NEIGHBOUR_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] CFG_RESET_VALUE = 5'd3;

    // Last value of the drain counter while the distance pipeline empties
    localparam logic [1:0] DRAIN_LAST = 2'd3;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_VOTE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic                      command;
        logic [SLOT_W-1:0]         slot;
        logic signed [FIELD_W-1:0] coord_x;
        logic signed [FIELD_W-1:0] coord_y;
        logic                      label;
        logic                      tie_guess;
    } in_item_t;

    typedef struct packed {
        logic              predicted_class;
        logic [VOTE_W-1:0] votes_one;
        logic [VOTE_W-1:0] votes_zero;
    } out_item_t;

    typedef struct packed {
        logic clear;
        logic insert;
        logic vote;
    } sort_ctrl_t;

endpackage

// File: hdl/knn_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// knn_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module knn_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/knn_dist.sv
`timescale 1ns / 1ps
// ============================================================================
// knn_dist
// Three-stage squared Euclidean distance pipeline: difference magnitude,
// squares, sum.
// ============================================================================
module knn_dist #(
    parameter int COORD_BITS = 16,
    parameter int DIST_W     = 35
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    input  logic signed [COORD_BITS-1:0] query_x,
    input  logic signed [COORD_BITS-1:0] query_y,
    input  logic signed [COORD_BITS-1:0] train_x,
    input  logic signed [COORD_BITS-1:0] train_y,
    input  logic                         train_label,
    output logic                         out_valid,
    output logic [DIST_W-1:0]            out_dist,
    output logic                         out_label
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;

    logic signed [DIFF_W-1:0] diff_x, diff_y;
    logic [DIFF_W-1:0]        mag_x_next, mag_y_next;
    logic [DIFF_W-1:0]        mag_x_reg, mag_y_reg;
    logic [SQ_W-1:0]          sq_x_next, sq_y_next;
    logic [SQ_W-1:0]          sq_x_reg, sq_y_reg;
    logic [DIST_W-1:0]        dist_next, dist_reg;
    logic                     lab1_reg, lab2_reg, lab3_reg;
    logic                     v1_reg, v2_reg, v3_reg;

    always_comb begin
        diff_x     = DIFF_W'(query_x) - DIFF_W'(train_x);
        diff_y     = DIFF_W'(query_y) - DIFF_W'(train_y);
        mag_x_next = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
        mag_y_next = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
        sq_x_next  = {{DIFF_W{1'b0}}, mag_x_reg} * {{DIFF_W{1'b0}}, mag_x_reg};
        sq_y_next  = {{DIFF_W{1'b0}}, mag_y_reg} * {{DIFF_W{1'b0}}, mag_y_reg};
        dist_next  = DIST_W'({1'b0, sq_x_reg}) + DIST_W'({1'b0, sq_y_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        mag_x_reg <= mag_x_next;
        mag_y_reg <= mag_y_next;
        lab1_reg  <= train_label;
        sq_x_reg  <= sq_x_next;
        sq_y_reg  <= sq_y_next;
        lab2_reg  <= lab1_reg;
        dist_reg  <= dist_next;
        lab3_reg  <= lab2_reg;
    end

    assign out_valid = v3_reg;
    assign out_dist  = dist_reg;
    assign out_label = lab3_reg;

endmodule

// File: hdl/knn_sort.sv
`timescale 1ns / 1ps
// ============================================================================
// knn_sort
// Sorted insertion list of the nearest distances seen so far, and the
// label count over its first k entries.
// ============================================================================
module knn_sort #(
    parameter int LIST_N = 16,
    parameter int DIST_W = 35
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  knn_pkg::sort_ctrl_t         ctrl,
    input  logic [DIST_W-1:0]           in_dist,
    input  logic                        in_label,
    input  logic [knn_pkg::VOTE_W-1:0]  k,
    output logic [knn_pkg::VOTE_W-1:0]  ones,
    output logic [knn_pkg::VOTE_W-1:0]  zeros
);

    import knn_pkg::*;

    logic [DIST_W-1:0] dist_reg  [LIST_N];
    logic [DIST_W-1:0] dist_next [LIST_N];
    logic [DIST_W-1:0] dist_prev [LIST_N];
    logic [LIST_N-1:0] label_reg, label_next, label_prev;
    logic [LIST_N-1:0] valid_reg, valid_next, valid_prev;
    logic [LIST_N-1:0] le, le_prev, kmask;
    logic [VOTE_W-1:0] ones_reg, zeros_reg;

    always_comb begin
        for (int i = 0; i < LIST_N; i++) begin
            le[i]    = valid_reg[i] && (dist_reg[i] <= in_dist);
            kmask[i] = VOTE_W'(i) < k;
        end
        le_prev[0]    = 1'b1;
        valid_prev[0] = 1'b1;
        label_prev[0] = in_label;
        dist_prev[0]  = in_dist;
        for (int i = 1; i < LIST_N; i++) begin
            le_prev[i]    = le[i-1];
            valid_prev[i] = valid_reg[i-1];
            label_prev[i] = label_reg[i-1];
            dist_prev[i]  = dist_reg[i-1];
        end

        dist_next  = dist_reg;
        label_next = label_reg;
        valid_next = valid_reg;
        if (ctrl.clear) begin
            valid_next = '0;
        end else if (ctrl.insert) begin
            // Equal distances stay ahead: later slots land behind them
            for (int i = 0; i < LIST_N; i++) begin
                if (!le[i]) begin
                    valid_next[i] = valid_reg[i] | valid_prev[i];
                    if (le_prev[i]) begin
                        dist_next[i]  = in_dist;
                        label_next[i] = in_label;
                    end else begin
                        dist_next[i]  = dist_prev[i];
                        label_next[i] = label_prev[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dist_reg  <= dist_next;
        label_reg <= label_next;
        if (ctrl.vote) begin
            ones_reg  <= VOTE_W'($countones(label_reg & valid_reg & kmask));
            zeros_reg <= VOTE_W'($countones(~label_reg & valid_reg & kmask));
        end
    end

    assign ones  = ones_reg;
    assign zeros = zeros_reg;

endmodule

// File: hdl/knn_binary_classifier.sv
`timescale 1ns / 1ps
// ============================================================================
// knn_binary_classifier
// Two-class k-nearest-neighbor classifier over a small training table.
// ============================================================================
// Usage:
//   Input beats on s_valid/s_ready carry one in_item_t. A load beat
//   (command = load) writes point and label into the training slot and
//   gives no result. A query beat measures the squared distance to slots
//   0..n-1, keeps the k nearest (lower slot wins a tie of distance) and
//   returns one out_item_t beat on m_valid/m_ready with the majority
//   class and both vote counts; a tied vote returns the inverse of
//   tie_guess.
//   Flow of a query, n being points_in_use clamped to MAX_POINTS: s_ready
//   stays low from the accept until the result is loaded into the output
//   register, so one query runs at a time; with n of 0 the scan and drain
//   are skipped. The scan reads one slot per cycle through the single read
//   port of the training memory; then the memory read and the 3-stage
//   distance pipeline drain, the votes are counted and the result loaded.
//   cfg_we/cfg_index/cfg_wdata write points_in_use and neighbour_count
//   (both reset to 3); write them only while the block is idle.
//   Reset (aresetn low, synchronous) clears control state; the training
//   table is not cleared and must be loaded before it is queried.
//   When m_ready is low the result holds in the output register; loads are
//   still taken, and a following query waits in its last step until the
//   output register frees.
// ============================================================================
module knn_binary_classifier #(
    parameter int MAX_POINTS = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  knn_pkg::in_item_t               s_item,
    // Result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output knn_pkg::out_item_t              m_item,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [knn_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [knn_pkg::CFG_W-1:0]       cfg_wdata
);

    import knn_pkg::*;

    localparam int AW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int DIST_W  = 2 * DIFF_W + 1;
    localparam int WORD_W  = 2 * COORD_BITS + 1;
    // Vote counts are 5 bits wide, so k never exceeds 31
    localparam int LIST_N  = (MAX_POINTS < 31) ? MAX_POINTS : 31;
    localparam logic [8:0]       MAX_EXT = 9'(MAX_POINTS);
    localparam logic [CFG_W-1:0] MAX_CNT = CFG_W'(MAX_POINTS);

    // ------------------------------------------------------------------
    // Control and configuration registers
    // ------------------------------------------------------------------
    state_t           state_reg, state_next;
    logic [CFG_W-1:0] points_in_use_reg, neighbour_count_reg;
    logic [CFG_W-1:0] n_eff_reg, k_eff_reg;
    logic [CFG_W-1:0] n_clamped, k_clamped;
    logic [CFG_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic [1:0]       drain_cnt_reg, drain_cnt_next;
    logic             rd_valid_reg;
    logic             rd_issue;
    logic             sort_vote;
    logic             out_load;
    logic             m_valid_reg;
    out_item_t        m_item_reg, out_next;

    // Query operands held for the whole scan
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg;
    logic                         tie_reg;

    logic              in_accept, query_accept, load_accept;
    logic [31:0]       in_x_raw, in_y_raw;
    logic [8:0]        slot_ext, scan_ext;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic              ram_we;

    logic              dist_valid, dist_label;
    logic [DIST_W-1:0] dist_value;
    sort_ctrl_t        sort_ctrl;
    logic [VOTE_W-1:0] vote_ones, vote_zeros;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    assign s_ready      = (state_reg == ST_IDLE);
    assign in_accept    = s_valid && s_ready;
    assign query_accept = in_accept && (s_item.command == CMD_QUERY);
    assign load_accept  = in_accept && (s_item.command == CMD_LOAD);

    // Keep the low COORD_BITS of each coordinate as a signed value
    assign in_x_raw = {16'b0, s_item.coord_x};
    assign in_y_raw = {16'b0, s_item.coord_y};

    // Drop loads to slots beyond the table
    assign slot_ext  = {5'b0, s_item.slot};
    assign ram_we    = load_accept && (slot_ext < MAX_EXT);
    assign ram_waddr = slot_ext[AW-1:0];
    assign ram_wdata = {s_item.label, in_y_raw[COORD_BITS-1:0], in_x_raw[COORD_BITS-1:0]};

    assign scan_ext  = {4'b0, scan_cnt_reg};
    assign ram_raddr = scan_ext[AW-1:0];

    // Clamp n to the table size and k to n
    always_comb begin
        n_clamped = ({4'b0, points_in_use_reg} > MAX_EXT) ? MAX_CNT : points_in_use_reg;
        k_clamped = (neighbour_count_reg > n_clamped) ? n_clamped : neighbour_count_reg;
    end

    // ------------------------------------------------------------------
    // Training table: {label, y, x} per slot
    // ------------------------------------------------------------------
    knn_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_train_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    knn_dist #(
        .COORD_BITS (COORD_BITS),
        .DIST_W     (DIST_W)
    ) u_dist (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (rd_valid_reg),
        .query_x     (qx_reg),
        .query_y     (qy_reg),
        .train_x     (ram_rdata[COORD_BITS-1:0]),
        .train_y     (ram_rdata[2*COORD_BITS-1:COORD_BITS]),
        .train_label (ram_rdata[WORD_W-1]),
        .out_valid   (dist_valid),
        .out_dist    (dist_value),
        .out_label   (dist_label)
    );

    assign sort_ctrl = '{clear: query_accept, insert: dist_valid, vote: sort_vote};

    knn_sort #(
        .LIST_N (LIST_N),
        .DIST_W (DIST_W)
    ) u_sort (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (sort_ctrl),
        .in_dist  (dist_value),
        .in_label (dist_label),
        .k        (k_eff_reg),
        .ones     (vote_ones),
        .zeros    (vote_zeros)
    );

    // ------------------------------------------------------------------
    // Sequencer: scan slots, drain the pipeline, vote, hand off result
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        drain_cnt_next = drain_cnt_reg;
        rd_issue       = 1'b0;
        sort_vote      = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (query_accept) begin
                    scan_cnt_next = '0;
                    // No slot in use: go straight to an empty vote
                    state_next = (n_clamped == '0) ? ST_VOTE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_issue      = 1'b1;
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == n_eff_reg - 1'b1) begin
                    drain_cnt_next = '0;
                    state_next     = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                drain_cnt_next = drain_cnt_reg + 1'b1;
                if (drain_cnt_reg == DRAIN_LAST) begin
                    state_next = ST_VOTE;
                end
            end
            ST_VOTE: begin
                sort_vote  = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                // Hold until the output register frees
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_next.votes_one  = vote_ones;
        out_next.votes_zero = vote_zeros;
        if (vote_ones > vote_zeros) begin
            out_next.predicted_class = 1'b1;
        end else if (vote_zeros > vote_ones) begin
            out_next.predicted_class = 1'b0;
        end else begin
            out_next.predicted_class = ~tie_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            points_in_use_reg   <= CFG_RESET_VALUE;
            neighbour_count_reg <= CFG_RESET_VALUE;
            scan_cnt_reg        <= '0;
            drain_cnt_reg       <= '0;
            rd_valid_reg        <= 1'b0;
            m_valid_reg         <= 1'b0;
            n_eff_reg           <= '0;
            k_eff_reg           <= '0;
        end else begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            drain_cnt_reg <= drain_cnt_next;
            rd_valid_reg  <= rd_issue;
            if (cfg_we) begin
                case (cfg_index)
                    REG_POINTS_IN_USE:   points_in_use_reg   <= cfg_wdata;
                    REG_NEIGHBOUR_COUNT: neighbour_count_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (query_accept) begin
                n_eff_reg <= n_clamped;
                k_eff_reg <= k_clamped;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (query_accept) begin
            qx_reg  <= in_x_raw[COORD_BITS-1:0];
            qy_reg  <= in_y_raw[COORD_BITS-1:0];
            tie_reg <= s_item.tie_guess;
        end
        if (out_load) begin
            m_item_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Every voting slot counts once: the two tallies add up to k
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (6'(vote_ones) + 6'(vote_zeros) == 6'(k_eff_reg)))
        else $error("vote tallies do not add up to k");

    // The scan never reads past the slots in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg < n_eff_reg))
        else $error("scan ran past points in use");

    // A query leaves idle for the scan or, with no slots, the vote
    assert property (@(posedge aclk) disable iff (!aresetn)
        query_accept |=> (state_reg == ST_SCAN || state_reg == ST_VOTE))
        else $error("query did not start the scan");

endmodule

// File: bench/knn_vote_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// knn_vote_checker
// Watches the input, result and register ports of the classifier, keeps its
// own training table and register copies, predicts the vote of every query
// beat and compares each result beat with the oldest prediction.
// ============================================================================
module knn_vote_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  knn_pkg::in_item_t               s_item,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  knn_pkg::out_item_t              m_item,
    input  logic                            cfg_we,
    input  logic [knn_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [knn_pkg::CFG_W-1:0]       cfg_wdata,
    output int                              fail_count,
    output int                              pending
);

    import knn_pkg::*;

    localparam int TABLE_DEPTH = 1 << SLOT_W;

    logic signed [FIELD_W-1:0] table_x [TABLE_DEPTH];
    logic signed [FIELD_W-1:0] table_y [TABLE_DEPTH];
    logic                      table_label [TABLE_DEPTH];
    logic [CFG_W-1:0]          points_in_use;
    logic [CFG_W-1:0]          neighbour_count;

    out_item_t vote_q [$];
    int        mismatches = 0;
    int        waiting = 0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Squared distance to each slot in use; a slot's rank is the number of
    // slots strictly nearer, the lower slot winning equal distances.
    function automatic out_item_t nearest_vote(input logic signed [FIELD_W-1:0] qx,
                                               input logic signed [FIELD_W-1:0] qy,
                                               input logic guess);
        longint unsigned sq_dist [TABLE_DEPTH];
        longint          dx, dy;
        int              n, k, rank, i, j;
        logic [VOTE_W-1:0] ones, zeros;
        out_item_t       res;
        n = (points_in_use > TABLE_DEPTH) ? TABLE_DEPTH : int'(points_in_use);
        k = (neighbour_count > n) ? n : int'(neighbour_count);
        ones  = '0;
        zeros = '0;
        for (i = 0; i < n; i++) begin
            dx = longint'($signed(qx)) - longint'($signed(table_x[i]));
            dy = longint'($signed(qy)) - longint'($signed(table_y[i]));
            sq_dist[i] = longint'(dx * dx) + longint'(dy * dy);
        end
        for (i = 0; i < n; i++) begin
            rank = 0;
            for (j = 0; j < n; j++) begin
                if (j != i && (sq_dist[j] < sq_dist[i] ||
                               (sq_dist[j] == sq_dist[i] && j < i)))
                    rank++;
            end
            if (rank < k) begin
                if (table_label[i])
                    ones++;
                else
                    zeros++;
            end
        end
        if (ones > zeros)
            res.predicted_class = 1'b1;
        else if (zeros > ones)
            res.predicted_class = 1'b0;
        else
            res.predicted_class = ~guess;
        res.votes_one  = ones;
        res.votes_zero = zeros;
        return res;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            points_in_use   = CFG_RESET_VALUE;
            neighbour_count = CFG_RESET_VALUE;
            vote_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_POINTS_IN_USE:   points_in_use   = cfg_wdata;
                    REG_NEIGHBOUR_COUNT: neighbour_count = cfg_wdata;
                    default: ;
                endcase
            end
            // retire a result beat before taking a new input beat
            if (m_valid && m_ready) begin
                if (vote_q.size() == 0) begin
                    report_mismatch("unexpected result beat", 1, 0);
                end else begin
                    want = vote_q.pop_front();
                    if (m_item.predicted_class !== want.predicted_class)
                        report_mismatch("predicted_class", m_item.predicted_class,
                                        want.predicted_class);
                    if (m_item.votes_one !== want.votes_one)
                        report_mismatch("votes_one", m_item.votes_one, want.votes_one);
                    if (m_item.votes_zero !== want.votes_zero)
                        report_mismatch("votes_zero", m_item.votes_zero, want.votes_zero);
                end
            end
            if (s_valid && s_ready) begin
                if (s_item.command == CMD_LOAD) begin
                    table_x[s_item.slot]     = s_item.coord_x;
                    table_y[s_item.slot]     = s_item.coord_y;
                    table_label[s_item.slot] = s_item.label;
                end else begin
                    vote_q.push_back(nearest_vote(s_item.coord_x, s_item.coord_y,
                                                  s_item.tie_guess));
                end
            end
        end
        waiting = vote_q.size();
    end

endmodule

// File: bench/knn_binary_classifier_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// knn_binary_classifier_tb
// Loads every training slot, runs a short directed set of queries over the
// corner cases of the vote, then random load/query traffic under a series of
// register settings, with random gaps on the input side and random stalls on
// the result side. A separate checker predicts and compares every result.
// ============================================================================
module knn_binary_classifier_tb;
    import knn_pkg::*;

    // Clock, reset and all block inputs start at known values
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_item    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_item;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    int fails;
    int pending;

    // Per-phase switches that remove idling on one side
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int rx_hold   = 0;

    always #1 aclk = ~aclk;

    knn_binary_classifier u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    knn_vote_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fails),
        .pending    (pending)
    );

    // Result side: after each accepted beat, drop ready for a random number
    // of cycles, then hold it high until the next beat goes through.
    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_hold = 0;
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                rx_hold = rx_steady ? 0 : $urandom_range(0, 17);
            else if (rx_hold != 0)
                rx_hold--;
            m_ready <= (rx_hold == 0);
        end
    end

    // Hang guard: also catches predictions that never get a result beat
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Idle for a random gap, then present one beat and hold it until taken.
    // Valid stays high across back-to-back beats.
    task automatic send_beat(input in_item_t beat);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_item  <= beat;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic load_point(input int slot, input int x, input int y, input logic lbl);
        in_item_t beat;
        beat           = '0;
        beat.command   = CMD_LOAD;
        beat.slot      = SLOT_W'(slot);
        beat.coord_x   = FIELD_W'(x);
        beat.coord_y   = FIELD_W'(y);
        beat.label     = lbl;
        beat.tie_guess = 1'($urandom_range(0, 1));
        send_beat(beat);
    endtask

    task automatic query_point(input int x, input int y, input logic guess);
        in_item_t beat;
        beat           = '0;
        beat.command   = CMD_QUERY;
        beat.slot      = SLOT_W'($urandom_range(0, 15));
        beat.coord_x   = FIELD_W'(x);
        beat.coord_y   = FIELD_W'(y);
        beat.label     = 1'($urandom_range(0, 1));
        beat.tie_guess = guess;
        send_beat(beat);
    endtask

    // Drop valid, wait until every predicted result has arrived, then let the
    // last load finish before anything touches the registers.
    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (32) @(posedge aclk);
    endtask

    // Write both registers on consecutive edges; the block is idle here
    task automatic set_config(input int points, input int neighbours);
        cfg_we    <= 1'b1;
        cfg_index <= REG_POINTS_IN_USE;
        cfg_wdata <= CFG_W'(points);
        @(posedge aclk);
        cfg_index <= REG_NEIGHBOUR_COUNT;
        cfg_wdata <= CFG_W'(neighbours);
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Mix full-range, extreme and clustered coordinates so that equal
    // distances and slot tie-breaks come up often.
    function automatic int rand_coord();
        int pick;
        pick = $urandom_range(0, 4);
        case (pick)
            0, 1:    rand_coord = int'($signed(16'($urandom)));
            2:       rand_coord = $urandom_range(0, 16) - 8;
            3:       rand_coord = $urandom_range(0, 1) ? 32767 : -32768;
            default: rand_coord = 1000 + $urandom_range(0, 4);
        endcase
    endfunction

    initial begin
        int preset_n [8];
        int preset_k [8];
        int phase, i, n, k;

        preset_n = '{16, 1, 0, 31, 16, 7, 20, 2};
        preset_k = '{16, 1, 5, 31, 0, 4, 3, 17};

        // Hold reset once at the start, then release it
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part ----
        // Fill every slot before any query so no unwritten slot is read:
        // the four corners of the plane, the origin, a duplicated point with
        // opposite labels, and a row of nearby points.
        load_point(0, -32768, -32768, 1'b0);
        load_point(1, 32767, 32767, 1'b1);
        load_point(2, -32768, 32767, 1'b1);
        load_point(3, 32767, -32768, 1'b0);
        load_point(4, 0, 0, 1'b1);
        load_point(5, 10, 10, 1'b0);
        load_point(6, 10, 10, 1'b1);
        load_point(7, -1, -1, 1'b0);
        for (i = 8; i < 16; i++)
            load_point(i, i * 100 - 700, 3 * i, i[0]);

        // Reset settings, largest distances
        query_point(32767, 32767, 1'b0);
        query_point(-32768, -32768, 1'b1);
        settle();

        // Whole table votes
        set_config(16, 16);
        query_point(0, 0, 1'b0);
        query_point(-32768, 32767, 1'b1);
        settle();

        // No point in use: empty vote, tie rule on both guesses
        set_config(0, 3);
        query_point(5, 5, 1'b0);
        query_point(5, 5, 1'b1);
        settle();

        // Two points at equal distance with opposite labels: tied vote
        set_config(7, 2);
        query_point(10, 10, 1'b1);
        query_point(10, 10, 1'b0);
        settle();

        // No neighbour votes
        set_config(16, 0);
        query_point(1, 1, 1'b0);
        settle();

        // Both registers above the table size: clamp
        set_config(31, 31);
        query_point(32767, -32768, 1'b1);
        settle();

        // ---- random part ----
        // Each phase writes new settings from an idle block, then streams
        // loads and queries; every fourth phase runs the sender gap-free and
        // every fifth the receiver stall-free.
        for (phase = 0; phase < 12; phase++) begin
            if (phase < 8) begin
                n = preset_n[phase];
                k = preset_k[phase];
            end else begin
                n = $urandom_range(1, 16);
                k = $urandom_range(1, 16);
            end
            set_config(n, k);
            tx_steady = (phase % 4 == 3);
            rx_steady = (phase % 5 == 2);
            for (i = 0; i < 160; i++) begin
                if ($urandom_range(0, 1))
                    query_point(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
                else
                    load_point($urandom_range(0, 15), rand_coord(), rand_coord(),
                               1'($urandom_range(0, 1)));
            end
            // Pause the sender until every result of the phase is in
            settle();
        end

        if (fails == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
hdl/knn_pkg.sv
hdl/knn_ram.sv
hdl/knn_dist.sv
hdl/knn_sort.sv
hdl/knn_binary_classifier.sv
bench/knn_vote_checker.sv
bench/knn_binary_classifier_tb.sv
